### src/ffea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffea_pkg
// Shared types and constants of the first-fit extent allocator.
// ============================================================================
package ffea_pkg;

    localparam int MAX_EXTENTS  = 16;
    localparam int HEADER_BYTES = 4;
    localparam int IDX_W        = $clog2(MAX_EXTENTS);
    localparam int CNT_W        = $clog2(MAX_EXTENTS + 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } extent_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        extent_t          wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage
`default_nettype wire

### src/ffea_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffea_table
// Free-extent table: one synchronous memory, one write and one registered
// read port.
// ============================================================================
module ffea_table (
    input  wire logic              clk,
    input  wire ffea_pkg::mem_req_t req,
    output ffea_pkg::extent_t       rdata
);

    ffea_pkg::extent_t mem [ffea_pkg::MAX_EXTENTS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule
`default_nettype wire

### src/ffea_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffea_ctrl
// Sequencer: scans the table entry by entry (read, then check), then shifts
// entries one at a time on inserts and removals; holds end pointer and count.
// ============================================================================
module ffea_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                op,
    input  wire logic [31:0]         s_in,
    input  wire logic [23:0]         len_in,
    output logic                     busy,
    output logic                     done,
    output logic [31:0]              res_offset,
    output ffea_pkg::status_t        res_status,
    output ffea_pkg::mem_req_t       mreq,
    input  wire ffea_pkg::extent_t   rdata
);

    localparam int IW = ffea_pkg::IDX_W;
    localparam int CW = ffea_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_AREAD, S_ACHK, S_ARM, S_FREAD, S_FCHK, S_FPREV, S_FDEC,
        S_INS, S_WR, S_RMV, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic              op_reg, op_next;
    logic [31:0]       s_reg, s_next;
    logic [32:0]       len_reg, len_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [31:0]       ep_reg, ep_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     i_reg, i_next;
    logic              jn_reg, jn_next;
    logic              jp_reg, jp_next;
    logic [32:0]       nl_reg, nl_next;
    ffea_pkg::extent_t prev_reg, prev_next;
    logic [31:0]       off_reg, off_next;
    ffea_pkg::status_t st_reg, st_next;
    logic              rmv_reg, rmv_next;
    ffea_pkg::mem_req_t m;

    logic [32:0] g_end, s_end, m_end;
    logic [31:0] ms;
    logic [33:0] ml;

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign res_offset = off_reg;
    assign res_status = st_reg;
    assign mreq       = m;
    assign g_end = {1'b0, rdata.start} + len_reg;
    assign s_end = {1'b0, s_reg} + len_reg;

    always_comb
    begin
        if (jp_reg)
        begin
            ms = prev_reg.start;
            ml = {2'b0, prev_reg.length} + {1'b0, len_reg} + (jn_reg ? {1'b0, nl_reg} : 34'd0);
        end
        else
        begin
            ms = s_reg;
            ml = {1'b0, len_reg} + (jn_reg ? {1'b0, nl_reg} : 34'd0);
        end
        m_end = {1'b0, ms} + ml[32:0];
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; s_next = s_reg; len_next = len_reg;
        cnt_next = cnt_reg; ep_next = ep_reg; pos_next = pos_reg;
        i_next = i_reg; jn_next = jn_reg; jp_next = jp_reg; nl_next = nl_reg;
        prev_next = prev_reg; off_next = off_reg; st_next = st_reg;
        rmv_next = rmv_reg;
        m = '0;
        m.raddr = i_reg[IW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    s_next   = s_in;
                    len_next = {9'd0, len_in} + 33'(ffea_pkg::HEADER_BYTES);
                    i_next   = '0;
                    off_next = '0;
                    st_next  = ffea_pkg::ST_OK;
                    jn_next  = 1'b0;
                    jp_next  = 1'b0;
                    if (op == ffea_pkg::OP_FREE)
                    begin
                        if ({1'b0, s_in} + {9'd0, len_in} + 33'(ffea_pkg::HEADER_BYTES) >
                            33'h0FFFFFFFF)
                        begin
                            len_next = 33'h0FFFFFFFF - {1'b0, s_in};
                        end
                        state_next = S_FREAD;
                    end
                    else
                    begin
                        state_next = S_AREAD;
                    end
                end
            end
            S_AREAD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    off_next = ep_reg;
                    if ({1'b0, ep_reg} + len_reg > 33'h0FFFFFFFF)
                    begin
                        st_next = ffea_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        ep_next = 32'(({1'b0, ep_reg} + len_reg));
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ACHK;
                end
            end
            S_ACHK:
            begin
                if ({1'b0, rdata.length} < len_reg)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_AREAD;
                end
                else
                begin
                    off_next = rdata.start;
                    if (rdata.start >= ep_reg)
                    begin
                        ep_next = g_end[31:0];
                    end
                    if ({1'b0, rdata.length} == len_reg)
                    begin
                        state_next = S_ARM;
                    end
                    else
                    begin
                        m.we = 1'b1;
                        m.waddr = i_reg[IW-1:0];
                        m.wdata.start = g_end[31:0];
                        m.wdata.length = rdata.length - len_reg[31:0];
                        state_next = S_DONE;
                    end
                end
            end
            S_ARM:
            begin
                pos_next = i_reg;
                cnt_next = cnt_reg - 1'b1;
                i_next = i_reg + 1'b1;
                rmv_next = 1'b0;
                state_next = S_RMV;
            end
            S_RMV:
            begin
                if (CW'(i_reg) >= cnt_reg + 1'b1)
                begin
                    state_next = S_DONE;
                end
                else if (rmv_reg)
                begin
                    m.we = 1'b1;
                    m.waddr = IW'(i_reg - 1'b1);
                    m.wdata = rdata;
                    i_next = i_reg + 1'b1;
                    rmv_next = 1'b0;
                end
                else
                begin
                    rmv_next = 1'b1;
                end
            end
            S_FREAD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    pos_next = i_reg;
                    state_next = (i_reg != '0) ? S_FPREV : S_FDEC;
                    i_next = i_reg - 1'b1;
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (s_reg < rdata.start)
                begin
                    pos_next = i_reg;
                    jn_next = (s_end == {1'b0, rdata.start});
                    nl_next = {1'b0, rdata.length};
                    state_next = (i_reg != '0) ? S_FPREV : S_FDEC;
                    i_next = i_reg - 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_FREAD;
                end
            end
            S_FPREV:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                prev_next = rdata;
                jp_next = ({1'b0, rdata.start} + {1'b0, rdata.length} == {1'b0, s_reg});
                state_next = S_FDEC;
            end
            S_FDEC:
            begin
                if (m_end == {1'b0, ep_reg})
                begin
                    ep_next = ms;
                    cnt_next = jp_reg ? CW'(pos_reg - 1'b1) : pos_reg;
                    state_next = S_DONE;
                end
                else if (jp_reg || jn_reg)
                begin
                    m.we = 1'b1;
                    m.waddr = jp_reg ? IW'(pos_reg - 1'b1) : pos_reg[IW-1:0];
                    m.wdata.start = ms;
                    m.wdata.length = ml[31:0];
                    if (jp_reg && jn_reg)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        i_next = pos_reg + 1'b1;
                        rmv_next = 1'b0;
                        state_next = S_RMV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (cnt_reg >= CW'(ffea_pkg::MAX_EXTENTS))
                begin
                    st_next = ffea_pkg::ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next = cnt_reg;
                    rmv_next = 1'b0;
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                m.raddr = IW'(i_reg - 1'b1);
                if (i_reg == pos_reg)
                begin
                    m.we = 1'b1;
                    m.waddr = pos_reg[IW-1:0];
                    m.wdata.start = ms;
                    m.wdata.length = ml[31:0];
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end
                else if (rmv_reg)
                begin
                    m.we = 1'b1;
                    m.waddr = i_reg[IW-1:0];
                    m.wdata = rdata;
                    i_next = i_reg - 1'b1;
                    rmv_next = 1'b0;
                end
                else
                begin
                    rmv_next = 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ep_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ep_reg    <= ep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; s_reg <= s_next; len_reg <= len_next;
        pos_reg <= pos_next; i_reg <= i_next; jn_reg <= jn_next;
        jp_reg <= jp_next; nl_reg <= nl_next; prev_reg <= prev_next;
        off_reg <= off_next; st_reg <= st_next; rmv_reg <= rmv_next;
    end

endmodule
`default_nettype wire

### src/first_fit_extent_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// first_fit_extent_allocator
// First-fit allocator over a sorted free-extent table with coalescing.
// ============================================================================
// Channel  Dir  tdata fields (low bit first)
// s_axis   in   opcode[0], extent_start[32:1], payload_length[56:33]
// m_axis   out  granted_offset[31:0], status[33:32]
//
// One request is processed at a time. The table scan reads each entry
// through the registered memory read port and then checks it, and shifts
// on insert or removal read and then write each moved entry.
// A finished result sits in an output register; a new request is taken
// once that result is accepted. Reset empties the table immediately.
module first_fit_extent_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // opcode, extent_start, payload_length
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // granted_offset, status
);

    ffea_pkg::mem_req_t mreq;
    ffea_pkg::extent_t  rdata;
    ffea_pkg::status_t  st;
    logic               busy, done, start;
    logic [31:0]        off;
    logic [33:0]        out_reg;
    logic               ov_reg;

    assign s_axis_tready = !busy && !ov_reg;
    assign start = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {6'd0, out_reg};

    ffea_table u_table (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    ffea_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (s_axis_tdata[0]),
        .s_in       (s_axis_tdata[32:1]),
        .len_in     (s_axis_tdata[56:33]),
        .busy       (busy),
        .done       (done),
        .res_offset (off),
        .res_status (st),
        .mreq       (mreq),
        .rdata      (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (done)
        begin
            ov_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= {st, off};
        end
    end

endmodule
`default_nettype wire

### src/ffea_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffea_checker
// Port-level checks of the allocator, bound to the top level.
// ============================================================================
module ffea_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3) else $error("bad status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result not held");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("two accepts");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the first-fit extent allocator: a behavioral
// model of the free table and end pointer predicts every result beat.
// ============================================================================
module testbench;

    typedef struct packed {
        logic [31:0]       offset;
        ffea_pkg::status_t stat;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    logic [31:0] mdl_starts [ffea_pkg::MAX_EXTENTS];
    logic [31:0] mdl_lengths[ffea_pkg::MAX_EXTENTS];
    int          mdl_count;
    logic [31:0] mdl_end;

    grant_t      pending_grants[$];
    int          errors;
    int          beats_out;
    int          full_seen;
    int          ovf_seen;
    int          hold_cycles;
    int          cycle_count;
    logic [31:0] live_starts[$];
    logic [23:0] live_lens[$];

    first_fit_extent_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic drop_entry(input int idx);
        for (int i = idx; i + 1 < mdl_count; i++)
        begin
            mdl_starts[i]  = mdl_starts[i + 1];
            mdl_lengths[i] = mdl_lengths[i + 1];
        end
        if (mdl_count > 0)
            mdl_count--;
    endtask

    task automatic predict_alloc(input logic [63:0] need, output grant_t g);
        logic [63:0] base;
        g.stat = ffea_pkg::ST_OK;
        for (int i = 0; i < mdl_count; i++)
        begin
            if ({32'd0, mdl_lengths[i]} >= need)
            begin
                base = {32'd0, mdl_starts[i]};
                mdl_starts[i]  = 32'(base + need);
                mdl_lengths[i] = 32'({32'd0, mdl_lengths[i]} - need);
                if (mdl_lengths[i] == 32'd0)
                    drop_entry(i);
                g.offset = base[31:0];
                if (base >= {32'd0, mdl_end})
                    mdl_end = 32'(base + need);
                return;
            end
        end
        g.offset = mdl_end;
        if ({32'd0, mdl_end} + need > 64'hFFFF_FFFF)
        begin
            g.stat = ffea_pkg::ST_OVERFLOW;
            return;
        end
        mdl_end = 32'({32'd0, mdl_end} + need);
    endtask

    task automatic predict_free(input logic [63:0] s, input logic [63:0] len,
                                output grant_t g);
        int          pos;
        int          m;
        logic        jn;
        logic        jp;
        logic [63:0] ms;
        logic [63:0] ml;
        pos = 0;
        g.offset = 32'd0;
        g.stat = ffea_pkg::ST_OK;
        if (s + len > 64'hFFFF_FFFF)
            len = 64'hFFFF_FFFF - s;
        while (pos < mdl_count && !(s < {32'd0, mdl_starts[pos]}))
            pos++;
        jn = pos < mdl_count && s + len == {32'd0, mdl_starts[pos]};
        jp = pos > 0 &&
             {32'd0, mdl_starts[pos - 1]} + {32'd0, mdl_lengths[pos - 1]} == s;
        if (jp)
        begin
            m = pos - 1;
            ms = {32'd0, mdl_starts[m]};
            ml = {32'd0, mdl_lengths[m]} + len;
            if (jn)
            begin
                ml += {32'd0, mdl_lengths[pos]};
                drop_entry(pos);
            end
        end
        else
        begin
            m = pos;
            ms = s;
            ml = jn ? len + {32'd0, mdl_lengths[pos]} : len;
        end
        if (ms + ml == {32'd0, mdl_end})
        begin
            mdl_end = ms[31:0];
            mdl_count = m;
            return;
        end
        if (!jp && !jn)
        begin
            if (mdl_count >= ffea_pkg::MAX_EXTENTS)
            begin
                g.stat = ffea_pkg::ST_FULL;
                return;
            end
            for (int i = mdl_count; i > pos; i--)
            begin
                mdl_starts[i]  = mdl_starts[i - 1];
                mdl_lengths[i] = mdl_lengths[i - 1];
            end
            mdl_count++;
        end
        mdl_starts[m]  = ms[31:0];
        mdl_lengths[m] = ml[31:0];
    endtask

    // Sends one request beat and records the predicted result.
    task automatic send_request(input logic op, input logic [31:0] s,
                                input logic [23:0] len);
        grant_t      g;
        logic [63:0] need;
        need = {40'd0, len} + 64'(ffea_pkg::HEADER_BYTES);
        s_axis_tdata  <= {7'd0, len, s, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op == ffea_pkg::OP_ALLOC)
        begin
            predict_alloc(need, g);
            if (g.stat == ffea_pkg::ST_OK)
            begin
                live_starts.push_back(g.offset);
                live_lens.push_back(len);
            end
            else
                ovf_seen++;
        end
        else
        begin
            predict_free({32'd0, s}, need, g);
            if (g.stat == ffea_pkg::ST_FULL)
                full_seen++;
        end
        pending_grants.push_back(g);
        @(negedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic send_alloc(input logic [23:0] len);
        send_request(ffea_pkg::OP_ALLOC, $urandom, len);
    endtask

    task automatic send_free(input logic [31:0] s, input logic [23:0] len);
        send_request(ffea_pkg::OP_FREE, s, len);
    endtask

    task automatic free_live_random();
        int k;
        k = $urandom_range(0, live_starts.size() - 1);
        send_free(live_starts[k], live_lens[k]);
        live_starts.delete(k);
        live_lens.delete(k);
    endtask

    task automatic drain();
        while (pending_grants.size() != 0)
            @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (4 * ffea_pkg::MAX_EXTENTS + 10) @(negedge clk);
    endtask

    task automatic test_basic_ops();
        send_alloc(24'd0);
        send_alloc(24'd12);
        send_alloc(24'hFF_FFFF);
        send_alloc(24'd100);
        send_free(32'd4, 24'd12);
        send_free(32'd4, 24'd0);
        send_alloc(24'd0);
        send_alloc(24'd12);
        send_free(32'd16, 24'hFF_FFFF);
        send_free(32'hFFFF_FFF0, 24'd100);
        send_free(32'hFFFF_FFFF, 24'hFF_FFFF);
        drain();
    endtask

    // Sends frees that never merge until the table overflows.
    task automatic test_table_full();
        for (int i = 0; i < ffea_pkg::MAX_EXTENTS + 3; i++)
            send_free(32'h4000_0000 + 32'(i) * 32'h100, 24'd8);
        drain();
    endtask

    // Pushes the end pointer near the top so it overflows, then trims back.
    task automatic test_overflow();
        for (int i = 0; i < 300; i++)
            send_alloc(24'hFF_FFFF);
        send_alloc(24'hFF_FFFF);
        send_free(mdl_end - 32'h0100_0003, 24'hFF_FFFF);
        drain();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 170; i++)
        begin
            if (live_starts.size() != 0 && $urandom_range(0, 99) < 45)
                free_live_random();
            else if ($urandom_range(0, 19) == 0)
                send_free($urandom, 24'($urandom));
            else
                send_alloc($urandom_range(0, 9) == 0 ? 24'($urandom)
                                                     : 24'($urandom_range(0, 64)));
            if (i == 85)
                hold_cycles = 400;
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        grant_t exp_g;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_out++;
            if (pending_grants.size() == 0)
            begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_g = pending_grants.pop_front();
                if (m_axis_tdata[31:0] !== exp_g.offset)
                begin
                    $error("granted_offset expected %h actual %h",
                           exp_g.offset, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[33:32] !== exp_g.stat)
                begin
                    $error("status expected %0d actual %0d",
                           exp_g.stat, m_axis_tdata[33:32]);
                    errors++;
                end
            end
        end
    end

    // The receiver stalls on its own pattern, with one long hold-off on request.
    initial
    begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else if ((phase / 200) % 3 == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 64'd0;
        errors        = 0;
        beats_out     = 0;
        full_seen     = 0;
        ovf_seen      = 0;
        hold_cycles   = 0;
        mdl_count     = 0;
        mdl_end       = 32'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_basic_ops();
        test_table_full();
        test_overflow();
        test_random_traffic();
        if (pending_grants.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_grants.size());
            errors++;
        end
        $display("Checked %0d result beats: %0d table-full drops, %0d overflows.",
                 beats_out, full_seen, ovf_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
